// ===== rtl/mbps_pkg.sv =====
`default_nettype none

package mbps_pkg;

  // Depth of the byte window, one cell per byte.
  localparam int MAX_PATTERN_BYTES = 32;

  // The pattern registers hold 32 bytes, so the usable length is capped there too.
  localparam int PATTERN_BYTES = 32;
  localparam int LEN_CAP = (MAX_PATTERN_BYTES < PATTERN_BYTES) ? MAX_PATTERN_BYTES
                                                               : PATTERN_BYTES;

  localparam int LEN_W   = 6;
  localparam int PIDX_W  = 5;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PATTERN_LOW      = 3'd0,
    CFG_PATTERN_MID_LOW  = 3'd1,
    CFG_PATTERN_MID_HIGH = 3'd2,
    CFG_PATTERN_HIGH     = 3'd3,
    CFG_WILDCARD_MASK    = 3'd4,
    CFG_PATTERN_LENGTH   = 3'd5,
    CFG_MATCH_LIMIT      = 3'd6,
    CFG_BASE_ADDRESS     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  match_address;
    logic [COUNT_W-1:0] match_number;
    logic               limit_reached;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Selects pattern byte j out of the four concatenated pattern registers.
  function automatic logic [7:0] pat_byte(input logic [8*PATTERN_BYTES-1:0] pat,
                                          input logic [PIDX_W-1:0] j);
    return pat[{j, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/masked_byte_pattern_scanner_top.sv =====
`default_nettype none

// Masked byte pattern scanner.
// A region of memory streams in one byte per word on the input channel
// (in_valid / in_stall, payload in_data_byte and in_region_end). Each byte
// shifts into a row of window cells; every cell compares its byte against the
// pattern byte that lines up with it, and wildcard bits force a cell to agree.
// A full match sends one word on the result channel (out_valid / out_stall)
// carrying the start address, the match ordinal and a limit flag.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per
// cycle; the user must write it only while the scanner is idle, as the block does not enforce this.
// Throughput is one byte per cycle while in_stall is low, set by the combinational window compare.
// A result is pushed into the output buffer as its byte is accepted and is shown from the main register.
// The output side has a main register and a skid register, so input keeps
// flowing while one result waits; in_stall rises only when both are full.
// The byte flagged as region end is scanned normally, then the window and
// all counters clear for the next region.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// window and counters, and drops any pending result.

module masked_byte_pattern_scanner_top
  import mbps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_region_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ADDR_W-1:0]       out_match_address,
  output logic [COUNT_W-1:0]      out_match_number,
  output logic                    out_limit_reached
);

  // Configuration registers.
  logic [CFG_W-1:0]   pattern_low_r;
  logic [CFG_W-1:0]   pattern_mid_low_r;
  logic [CFG_W-1:0]   pattern_mid_high_r;
  logic [CFG_W-1:0]   pattern_high_r;
  logic [31:0]        wildcard_mask_r;
  logic [LEN_W-1:0]   pattern_length_r;
  logic [COUNT_W-1:0] match_limit_r;
  logic [ADDR_W-1:0]  base_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r      <= '0;
      pattern_mid_low_r  <= '0;
      pattern_mid_high_r <= '0;
      pattern_high_r     <= '0;
      wildcard_mask_r    <= '0;
      pattern_length_r   <= LEN_W'(1);
      match_limit_r      <= '0;
      base_address_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LOW:      pattern_low_r      <= cfg_data;
        CFG_PATTERN_MID_LOW:  pattern_mid_low_r  <= cfg_data;
        CFG_PATTERN_MID_HIGH: pattern_mid_high_r <= cfg_data;
        CFG_PATTERN_HIGH:     pattern_high_r     <= cfg_data;
        CFG_WILDCARD_MASK:    wildcard_mask_r    <= cfg_data[31:0];
        CFG_PATTERN_LENGTH:   pattern_length_r   <= cfg_data[LEN_W-1:0];
        CFG_MATCH_LIMIT:      match_limit_r      <= cfg_data[COUNT_W-1:0];
        CFG_BASE_ADDRESS:     base_address_r     <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length: a zero length acts as one, and long lengths
  // are capped at the window depth.
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    if (pattern_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length_r > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = pattern_length_r;
    end
  end

  logic [8*PATTERN_BYTES-1:0] pattern_all;
  assign pattern_all = {pattern_high_r, pattern_mid_high_r, pattern_mid_low_r, pattern_low_r};

  // Handshake.
  logic accept;
  assign accept = in_valid && !in_stall;

  cell_ctrl_t cell_ctrl;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && in_region_end;

  // Window cells. Cell 0 holds the newest byte; cell k lines up with
  // pattern byte len_eff-1-k, and cells at or beyond the length always agree.
  logic [7:0]                   cell_byte [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_hit;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [7:0]        byte_in;
    logic [PIDX_W-1:0] pidx;
    logic              active;

    if (k == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_link
      assign byte_in = cell_byte[k-1];
    end

    assign active = LEN_W'(k) < len_eff;
    assign pidx   = PIDX_W'(len_eff - LEN_W'(1) - LEN_W'(k));

    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .byte_in  (byte_in),
      .pat_in   (pat_byte(pattern_all, pidx)),
      .wild     (wildcard_mask_r[pidx]),
      .active   (active),
      .byte_out (cell_byte[k]),
      .hit      (cell_hit[k])
    );
  end

  // Region counters.
  logic [ADDR_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic [COUNT_W-1:0] matches_r, matches_nxt;
  logic               stopped_r, stopped_nxt;

  logic [ADDR_W-1:0]  seen_inc;
  logic [COUNT_W-1:0] matches_inc;
  logic               limit_on;
  logic               stop_pre;
  logic               enough;
  logic               match;
  logic               at_limit;
  result_t            result;

  assign seen_inc    = (bytes_seen_r == '1) ? bytes_seen_r : bytes_seen_r + ADDR_W'(1);
  assign matches_inc = (matches_r == '1) ? matches_r : matches_r + COUNT_W'(1);
  assign limit_on    = match_limit_r != '0;
  // Lowering the limit below the current count stops the scan at once.
  assign stop_pre    = stopped_r || (limit_on && (matches_r >= match_limit_r));
  assign enough      = seen_inc >= ADDR_W'(len_eff);
  assign match       = accept && !stop_pre && enough && (&cell_hit);
  assign at_limit    = limit_on && (matches_inc == match_limit_r);

  assign result.match_address = base_address_r + seen_inc - ADDR_W'(len_eff);
  assign result.match_number  = matches_inc;
  assign result.limit_reached = at_limit;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    matches_nxt    = matches_r;
    stopped_nxt    = stopped_r;
    if (accept) begin
      if (in_region_end) begin
        bytes_seen_nxt = '0;
        matches_nxt    = '0;
        stopped_nxt    = 1'b0;
      end else begin
        bytes_seen_nxt = seen_inc;
        matches_nxt    = match ? matches_inc : matches_r;
        stopped_nxt    = stop_pre || (match && at_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      matches_r    <= '0;
      stopped_r    <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      matches_r    <= matches_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // Output register with skid entry.
  result_t out_data;

  mbps_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (match),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (in_stall)
  );

  assign out_match_address = out_data.match_address;
  assign out_match_number  = out_data.match_number;
  assign out_limit_reached = out_data.limit_reached;

  // Nothing is reported once the scan has stopped.
  a_no_match_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    match |-> !stopped_r)
    else $error("match reported after scan stopped");

  // The last byte of a region leaves the counters empty.
  a_region_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_region_end) |=> (bytes_seen_r == '0 && matches_r == '0 && !stopped_r))
    else $error("region end did not clear counters");

  // Reaching the limit stops the scan for the rest of the region.
  a_limit_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (match && at_limit && !in_region_end) |=> stopped_r)
    else $error("limit reached without stopping");

  // A match always has enough bytes behind it for the whole pattern.
  a_match_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    match |-> (seen_inc >= ADDR_W'(len_eff)))
    else $error("match before pattern length bytes seen");

endmodule

`default_nettype wire

// ===== rtl/mbps_cell.sv =====
`default_nettype none

module mbps_cell
  import mbps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pat_in,
  input  wire logic       wild,
  input  wire logic       active,
  output logic [7:0]      byte_out,
  output logic            hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic [7:0] cur_byte;

  // The compare sees the window as it stands once the incoming word has shifted in.
  assign cur_byte = ctrl.shift ? byte_in : byte_r;
  assign hit      = !active || wild || (pat_in == cur_byte);

  always_comb begin
    if (ctrl.clear) begin
      byte_nxt = 8'd0;
    end else begin
      byte_nxt = cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

// ===== rtl/mbps_obuf.sv =====
`default_nettype none

module mbps_obuf
  import mbps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_data,
  output logic         full
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign full      = skid_v_r;

  // The skid entry is only ever used behind a waiting main entry.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid without main entry");

  // A push is never offered while the buffer reports full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("push while buffer full");

  // A stalled word with a full skid keeps the skid occupied.
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_stall) |=> skid_v_r)
    else $error("skid entry dropped while output stalled");

endmodule

`default_nettype wire

// ===== sim/masked_byte_pattern_scanner_top_test.sv =====
`default_nettype none

// Self-checking test of the masked byte pattern scanner.
// Bytes of a memory region go in one word at a time; every accepted byte is
// also fed to a behavioral scanner kept in this module, which queues the match
// word (if any) that the block must send back. A checker pops that queue on
// every word taken from the result channel and compares all three fields.
module masked_byte_pattern_scanner_top_test;
  import mbps_pkg::*;

  // The block holds at most two results, in its main and skid registers; the settle
  // time below is ample to see a late or stray word.
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BYTES  = 1150;
  localparam int RUN_BYTES     = 200;

  // One full setting of the eight configuration registers.
  typedef struct {
    logic [8*PATTERN_BYTES-1:0] pattern;
    logic [31:0]                wild;
    logic [LEN_W-1:0]           plen;
    logic [COUNT_W-1:0]         limit;
    logic [ADDR_W-1:0]          base;
  } scan_setting_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = CFG_PATTERN_LOW;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = '0;
  logic               in_region_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  out_match_address;
  logic [COUNT_W-1:0] out_match_number;
  logic               out_limit_reached;

  // Copy of the configuration registers as the block should hold them.
  logic [8*PATTERN_BYTES-1:0] pattern_bytes = '0;
  logic [31:0]                wild_bits = '0;
  logic [LEN_W-1:0]           pat_len = LEN_W'(1);
  logic [COUNT_W-1:0]         stop_count = '0;
  logic [ADDR_W-1:0]          region_base = '0;

  // Scan state of the behavioral scanner; recent_bytes[0] is the newest byte.
  logic [7:0]         recent_bytes [MAX_PATTERN_BYTES];
  logic [31:0]        region_bytes;
  logic [COUNT_W-1:0] region_matches;
  bit                 reporting_off;

  result_t expected_matches [$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      cycle_count = 0;
  // When set, neither side idles: bytes go in back to back and results are
  // taken as soon as they show up.
  bit      calm = 1'b0;
  int      stall_left = 0;

  masked_byte_pattern_scanner_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_region_end     (in_region_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_address (out_match_address),
    .out_match_number  (out_match_number),
    .out_limit_reached (out_limit_reached)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length of a random pause: mostly none or short, now and then long.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Pattern length as the block uses it: zero counts as one, and anything
  // longer than the window is cut down to the window.
  function automatic int active_length();
    int n;
    n = (pat_len == 0) ? 1 : int'(pat_len);
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  // Narrow registers ignore the upper bits of the write data, so those bits
  // are sometimes filled with noise.
  function automatic logic [CFG_W-1:0] with_noise(input logic [CFG_W-1:0] v, input int width);
    logic [CFG_W-1:0] noise;
    noise = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) return v | (noise & ({CFG_W{1'b1}} << width));
    return v;
  endfunction

  task automatic clear_region_state();
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    region_bytes   = '0;
    region_matches = '0;
    reporting_off  = 1'b0;
  endtask

  // Works out what the block must report for one accepted byte and queues it.
  task automatic predict_match(input logic [7:0] b, input bit last);
    int      n;
    bit      hit;
    result_t r;
    n = active_length();
    for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (region_bytes != 32'hFFFF_FFFF) region_bytes++;
    // Lowering the limit below the count already reached silences the region.
    if (stop_count != 0 && region_matches >= stop_count) reporting_off = 1'b1;
    if (!reporting_off && region_bytes >= 32'(n)) begin
      hit = 1'b1;
      // Pattern byte 0 lines up with the oldest byte of the window.
      for (int j = 0; j < n; j++)
        if (!wild_bits[j] && pattern_bytes[8*j +: 8] != recent_bytes[n-1-j]) hit = 1'b0;
      if (hit) begin
        // With no limit the ordinal sticks at its top value.
        if (region_matches != {COUNT_W{1'b1}}) region_matches++;
        r.match_address = region_base + (region_bytes - 32'(n));
        r.match_number  = region_matches;
        r.limit_reached = (stop_count != 0) && (region_matches == stop_count);
        if (r.limit_reached) reporting_off = 1'b1;
        expected_matches = {expected_matches, r};
      end
    end
    // The flagged byte is scanned first; only then does the region restart.
    if (last) clear_region_state();
  endtask

  // Sends one byte and waits until the block takes it. The handshake is read
  // at the falling edge, where it is settled for the next rising edge. Valid
  // stays high when no pause follows, so the next word goes out back to back.
  task automatic send_byte(input logic [7:0] b, input bit last);
    bit ready;
    int gap;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_region_end <= last;
    do begin
      @(negedge clk);
      ready = !in_stall;
      @(posedge clk);
    end while (!ready);
    predict_match(b, last);
    bytes_sent++;
    gap = calm ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off the sender until every queued result has come back, then lets
  // the block settle so that a register write finds it idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; write enable is left high so writes can go back to
  // back, and the caller lowers it after the last one.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      CFG_PATTERN_LOW:      pattern_bytes[63:0]    = v;
      CFG_PATTERN_MID_LOW:  pattern_bytes[127:64]  = v;
      CFG_PATTERN_MID_HIGH: pattern_bytes[191:128] = v;
      CFG_PATTERN_HIGH:     pattern_bytes[255:192] = v;
      CFG_WILDCARD_MASK:    wild_bits   = v[31:0];
      CFG_PATTERN_LENGTH:   pat_len     = v[LEN_W-1:0];
      CFG_MATCH_LIMIT:      stop_count  = v[COUNT_W-1:0];
      CFG_BASE_ADDRESS:     region_base = v[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_scanner(input scan_setting_t s);
    write_reg(CFG_PATTERN_LOW,      s.pattern[63:0]);
    write_reg(CFG_PATTERN_MID_LOW,  s.pattern[127:64]);
    write_reg(CFG_PATTERN_MID_HIGH, s.pattern[191:128]);
    write_reg(CFG_PATTERN_HIGH,     s.pattern[255:192]);
    write_reg(CFG_WILDCARD_MASK,    with_noise(CFG_W'(s.wild), 32));
    write_reg(CFG_PATTERN_LENGTH,   with_noise(CFG_W'(s.plen), LEN_W));
    write_reg(CFG_MATCH_LIMIT,      with_noise(CFG_W'(s.limit), COUNT_W));
    write_reg(CFG_BASE_ADDRESS,     with_noise(CFG_W'(s.base), ADDR_W));
    cfg_we <= 1'b0;
  endtask

  // A random setting; the first phases pin the extremes.
  function automatic scan_setting_t random_setting(input int phase);
    scan_setting_t s;
    int            r;
    for (int k = 0; k < 8; k++) s.pattern[32*k +: 32] = $urandom();
    case ($urandom_range(0, 3))
      0: s.wild = '0;
      1: s.wild = '1;
      2: s.wild = $urandom() & $urandom() & $urandom();
      default: s.wild = $urandom();
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) s.plen = '0;
    else if (r == 1) s.plen = LEN_W'($urandom_range(LEN_CAP + 1, 63));
    else if (r < 4) s.plen = LEN_W'($urandom_range(9, LEN_CAP));
    else s.plen = LEN_W'($urandom_range(1, 8));
    r = $urandom_range(0, 9);
    if (r < 4) s.limit = '0;
    else if (r < 8) s.limit = COUNT_W'($urandom_range(1, 4));
    else if (r == 8) s.limit = '1;
    else s.limit = COUNT_W'($urandom_range(5, 40));
    r = $urandom_range(0, 5);
    if (r == 0) s.base = '0;
    else if (r == 1) s.base = '1;
    else if (r == 2) s.base = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else s.base = $urandom();
    case (phase)
      0: begin
        s.plen = LEN_W'(LEN_CAP); s.wild = '0; s.limit = COUNT_W'(1); s.base = '0;
      end
      1: begin
        s.plen = '1; s.wild = '1; s.limit = '1; s.base = '1;
      end
      2: begin
        s.plen = '0; s.limit = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Sends one region built mostly from copies of the pattern (wildcard
  // positions filled at random, now and then one bit flipped) between filler
  // bytes drawn from the pattern itself, from noise and from the extremes.
  task automatic scan_region(input int span, input bit close);
    int         n;
    int         left;
    int         flip;
    int         r;
    logic [7:0] b;
    n = active_length();
    left = span;
    while (left > 0) begin
      if (left >= n && $urandom_range(0, 9) < 4) begin
        flip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int j = 0; j < n; j++) begin
          b = wild_bits[j] ? 8'($urandom()) : pattern_bytes[8*j +: 8];
          if (j == flip) b ^= 8'(1 << $urandom_range(0, 7));
          left--;
          send_byte(b, close && left == 0);
        end
      end else begin
        r = $urandom_range(0, 19);
        if (r < 9) b = 8'($urandom_range(0, 255));
        else if (r < 18) b = pattern_bytes[8*$urandom_range(0, n - 1) +: 8];
        else b = (r == 18) ? 8'h00 : 8'hFF;
        left--;
        send_byte(b, close && left == 0);
      end
    end
  endtask

  // After reset the pattern is a single zero byte with no wildcard, no limit
  // and base address zero.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();
  endtask

  // A wildcard in the middle of the pattern, and start addresses that wrap
  // past the top of the address space.
  task automatic test_wildcard_wrap();
    scan_setting_t s;
    s.pattern = '0;
    s.pattern[7:0]   = 8'h11;
    s.pattern[15:8]  = 8'h5A;
    s.pattern[23:16] = 8'hFF;
    s.wild  = 32'h0000_0002;
    s.plen  = LEN_W'(3);
    s.limit = '0;
    s.base  = 32'hFFFF_FFFE;
    program_scanner(s);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
  endtask

  // A length of zero behaves as a one-byte pattern.
  task automatic test_zero_length();
    scan_setting_t s;
    s.pattern = '0;
    s.pattern[7:0] = 8'h80;
    s.wild  = '0;
    s.plen  = '0;
    s.limit = '0;
    s.base  = 32'h0000_1000;
    program_scanner(s);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_results();
  endtask

  // A region shorter than the pattern can never match, even with every byte
  // a wildcard; the next region of exactly the pattern length matches once.
  task automatic test_short_region();
    scan_setting_t s;
    s.pattern = '0;
    s.wild  = '1;
    s.plen  = LEN_W'(4);
    s.limit = '0;
    s.base  = 32'h0000_0100;
    program_scanner(s);
    repeat (2) send_byte(8'($urandom()), 1'b0);
    send_byte(8'($urandom()), 1'b1);
    repeat (3) send_byte(8'($urandom()), 1'b0);
    send_byte(8'($urandom()), 1'b1);
    drain_results();
  endtask

  // The limit is lowered below the count already reached in an open region,
  // which silences the rest of it; the next region stops at the limit.
  task automatic test_limit_lowered();
    scan_setting_t s;
    s.pattern = '0;
    s.wild  = 32'h0000_0001;
    s.plen  = LEN_W'(1);
    s.limit = '0;
    s.base  = 32'h0000_0040;
    program_scanner(s);
    repeat (3) send_byte(8'($urandom()), 1'b0);
    drain_results();
    write_reg(CFG_MATCH_LIMIT, CFG_W'(2));
    cfg_we <= 1'b0;
    send_byte(8'($urandom()), 1'b0);
    send_byte(8'($urandom()), 1'b1);
    repeat (2) send_byte(8'($urandom()), 1'b0);
    send_byte(8'($urandom()), 1'b1);
    drain_results();
  endtask

  // With no limit and every byte matching, the ordinal climbs by one for each
  // byte sent back to back, and the start addresses wrap past the top of the
  // address space along the way.
  task automatic test_unlimited_run();
    scan_setting_t s;
    s.pattern = '0;
    s.wild  = '1;
    s.plen  = LEN_W'(1);
    s.limit = '0;
    s.base  = 32'hFFFF_FF80;
    program_scanner(s);
    calm = 1'b1;
    for (int i = 0; i < RUN_BYTES; i++) send_byte(8'($urandom()), i == RUN_BYTES - 1);
    drain_results();
    calm = 1'b0;
  endtask

  // Random settings, each followed by a few regions. Some regions are left
  // open, so the next setting lands in the middle of a scan. Every change of
  // setting first waits until all results are back.
  task automatic test_random_regions();
    scan_setting_t s;
    int            phase;
    int            first;
    int            n;
    int            span;
    phase = 0;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      s = random_setting(phase);
      drain_results();
      program_scanner(s);
      calm = ($urandom_range(0, 3) == 0);
      n = active_length();
      repeat ($urandom_range(2, 5)) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n)
                                           : $urandom_range(n, 3 * n + 12);
        scan_region(span, $urandom_range(0, 6) != 0);
      end
      phase++;
    end
    drain_results();
    calm = 1'b0;
  endtask

  // Result side stall: random bursts of stall, none while calm.
  always @(posedge clk) begin
    int s;
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      s = idle_span();
      out_stall <= (s > 0);
      stall_left = (s > 0) ? s - 1 : 0;
    end
  end

  // A result word is taken at the rising edge that follows a falling edge
  // with valid high and stall low, so it is checked at that falling edge.
  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match word: address %h number %0d limit %b",
                 $time, out_match_address, out_match_number, out_limit_reached);
        mismatches++;
      end else begin
        want = expected_matches.pop_front();
        if (out_match_address !== want.match_address) begin
          $display("%0t: match_address expected %h actual %h",
                   $time, want.match_address, out_match_address);
          mismatches++;
        end
        if (out_match_number !== want.match_number) begin
          $display("%0t: match_number expected %0d actual %0d",
                   $time, want.match_number, out_match_number);
          mismatches++;
        end
        if (out_limit_reached !== want.limit_reached) begin
          $display("%0t: limit_reached expected %b actual %b",
                   $time, want.limit_reached, out_limit_reached);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_region_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_wildcard_wrap();
    test_zero_length();
    test_short_region();
    test_limit_lowered();
    test_unlimited_run();
    test_random_regions();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== masked_byte_pattern_scanner_top.f =====
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/mbps_obuf.sv
rtl/masked_byte_pattern_scanner_top.sv
sim/masked_byte_pattern_scanner_top_test.sv
